[design/jrr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrr_pkg
// Shared types, protocol constants and byte helpers for the J1939 responder.
// ----------------------------------------------------------------------------
package jrr_pkg;

    // Protocol format and control codes
    localparam logic [7:0]  PF_ACK        = 8'hE8;
    localparam logic [7:0]  PF_REQUEST    = 8'hEA;
    localparam logic [7:0]  PF_TP_DT      = 8'hEB;
    localparam logic [7:0]  PF_TP_CM      = 8'hEC;
    localparam logic [7:0]  PF_ADDR_CLAIM = 8'hEE;
    localparam logic [23:0] PGN_ADDR_CLAIM = 24'h00EE00;
    localparam logic [23:0] PGN_ECU_IDENT  = 24'h00FDC5;
    localparam logic [23:0] PGN_DIAG1      = 24'h00FECA;
    localparam logic [7:0]  CTL_NACK  = 8'h01;
    localparam logic [7:0]  CTL_RTS   = 8'h10;
    localparam logic [7:0]  CTL_BAM   = 8'h20;
    localparam logic [7:0]  CTL_ABORT = 8'hFF;
    localparam logic [7:0]  ADDR_GLOBAL = 8'hFF;
    localparam logic [2:0]  MAX_DATA_PKTS = 3'd5;

    // Configuration register indexes
    localparam logic [1:0] REG_SOURCE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_ECU_NAME       = 2'd1;
    localparam logic [1:0] REG_DTC_COUNT      = 2'd2;

    typedef struct packed {
        logic        func;
        logic        is_extended;
        logic [28:0] can_id;
        logic [6:0]  byte_count;
        logic [63:0] payload;
        logic        mil_lamp;
        logic [2:0]  dtc_index;
        logic [31:0] dtc_code;
    } in_item_t;

    typedef struct packed {
        logic [28:0] tx_id;
        logic [63:0] tx_payload;
        logic        last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEC,
        ST_FILL,
        ST_SEND
    } state_t;

    // Build a 29-bit identifier
    function automatic logic [28:0] mk_id(input logic [2:0] prio, input logic [7:0] pf,
                                          input logic [7:0] da, input logic [7:0] sa);
        mk_id = {prio, 2'b00, pf, da, sa};
    endfunction

    // PGN-tagged control frame: ctl, four 0xFF, PGN in bytes 5..7
    function automatic logic [63:0] ctl_frame(input logic [7:0] ctl, input logic [23:0] pgn);
        ctl_frame = {pgn, 32'hFFFF_FFFF, ctl};
    endfunction

    // Identification string, padded with spaces
    function automatic logic [7:0] ident_byte(input logic [5:0] k);
        unique case (k)
            6'd0:  ident_byte = 8'h52;
            6'd1:  ident_byte = 8'h41;
            6'd2:  ident_byte = 8'h4D;
            6'd3:  ident_byte = 8'h4E;
            6'd4:  ident_byte = 8'h2A;
            6'd5:  ident_byte = 8'h45;
            6'd6:  ident_byte = 8'h43;
            6'd7:  ident_byte = 8'h55;
            6'd8:  ident_byte = 8'h5F;
            6'd9:  ident_byte = 8'h41;
            6'd10: ident_byte = 8'h2A;
            6'd11: ident_byte = 8'h30;
            6'd12: ident_byte = 8'h30;
            6'd13: ident_byte = 8'h30;
            6'd14: ident_byte = 8'h31;
            6'd15: ident_byte = 8'h2A;
            6'd16: ident_byte = 8'h55;
            6'd17: ident_byte = 8'h4E;
            6'd18: ident_byte = 8'h49;
            6'd19: ident_byte = 8'h54;
            6'd20: ident_byte = 8'h31;
            6'd21: ident_byte = 8'h2A;
            default: ident_byte = 8'h20;
        endcase
    endfunction

    // Map a trouble code to the four DM1 bytes {b3, b2, b1, b0}
    function automatic logic [31:0] spn_bytes(input logic [31:0] code);
        logic [13:0] fault;
        logic [1:0]  cat;
        logic [15:0] spn;
        logic [4:0]  fmi;
        fault = code[29:16];
        cat   = code[31:30];
        spn   = {2'b00, fault};
        fmi   = 5'd31;
        priority if (cat == 2'd3 && fault == 14'h0029)
        begin
            spn = 16'd639;
            fmi = 5'd9;
        end
        else if (cat == 2'd1 && fault == 14'h0563)
        begin
            spn = 16'd628;
            fmi = 5'd13;
        end
        else if (cat == 2'd0 && fault == 14'h0172)
        begin
            spn = 16'd3055;
            fmi = 5'd0;
        end
        else if (cat == 2'd2 && fault == 14'h0091)
        begin
            spn = 16'd2872;
            fmi = 5'd2;
        end
        spn_bytes = {8'h01, 3'b000, fmi, spn[15:8], spn[7:0]};
    endfunction

endpackage

[design/jrr_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrr_in_if
// Valid/ready channel carrying received frames and store writes.
// ----------------------------------------------------------------------------
interface jrr_in_if;
    logic              valid;
    logic              ready;
    jrr_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/jrr_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrr_out_if
// Valid/ready channel carrying frames to send.
// ----------------------------------------------------------------------------
interface jrr_out_if;
    logic               valid;
    logic               ready;
    jrr_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/j1939_request_responder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// j1939_request_responder
// Answers J1939 requests (address claim, ECU identification, DM1), NACKs
// unknown directed requests and aborts RTS sessions aimed at this node.
// ----------------------------------------------------------------------------
// Channel   Dir  Item
// in_ch     in   received frame or trouble code store write
// out_ch    out  frame to send, last marks end of a response
// APB       in   source_address @0x00, ecu_name @0x08, dtc_count @0x10
//
// A store write or a standard-identifier frame is handled in ST_IDLE; an
// extended frame is captured, then decoded in ST_DEC, and single frames then go
// out. Each BAM data packet is assembled by one shared byte unit, one byte per
// cycle in ST_FILL, then sent from ST_SEND. in_ch.ready is high only while no
// response is in progress; out_ch stalls hold the sequencer. Reset clears
// control state and the config registers.
// ----------------------------------------------------------------------------
module j1939_request_responder #(
    parameter int DTC_DEPTH = 8,
    parameter int ID_LEN    = 22
) (
    input  logic        clk,
    input  logic        rst_n,
    jrr_in_if.sink      in_ch,
    jrr_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int IW      = $clog2(DTC_DEPTH);
    localparam int ROM_LEN = (ID_LEN > 64) ? 64 : ID_LEN;

    // Configuration registers
    logic [7:0]  sa_reg;
    logic [63:0] name_reg;
    logic [3:0]  count_reg;

    // Trouble code store
    logic [31:0] store_reg [DTC_DEPTH];

    // Sequencer state
    jrr_pkg::state_t state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    jrr_pkg::out_item_t out_reg, out_next;
    jrr_pkg::in_item_t  item_reg, item_next;
    logic        dm1_reg, dm1_next;
    logic [6:0]  total_reg, total_next;
    logic [2:0]  sent_reg, sent_next;
    logic [2:0]  seq_reg, seq_next;
    logic [6:0]  ptr_reg, ptr_next;
    logic [2:0]  byte_cnt_reg, byte_cnt_next;
    logic [55:0] buf_reg, buf_next;

    logic        in_fire, out_fire, cfg_wr;
    logic        store_wr;
    logic [IW-1:0] wr_idx;

    // Decode helpers
    logic [7:0]  pf, ps, rsa;
    logic [23:0] req_pgn;
    logic        is_req, is_rts;
    logic [4:0]  dtc_n;
    logic [6:0]  bam_total;
    logic [6:0]  pkts_arg;
    logic [12:0] pkts_prod;
    logic [4:0]  pkts;
    logic [2:0]  sent_cnt;
    logic [7:0]  lamp_byte;
    logic [6:0]  dtc_off;
    logic [3:0]  dtc_ent;
    logic [31:0] dtc_code_rd;
    logic [31:0] dtc_bytes;
    logic [7:0]  fill_byte;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;

    assign in_ch.ready  = (state_reg == jrr_pkg::ST_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_reg    <= 8'd128;
            name_reg  <= 64'd0;
            count_reg <= 4'd0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:3])
                jrr_pkg::REG_SOURCE_ADDRESS: sa_reg    <= pwdata[7:0];
                jrr_pkg::REG_ECU_NAME:       name_reg  <= pwdata;
                jrr_pkg::REG_DTC_COUNT:      count_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Configuration read
    always_comb
    begin
        unique case (paddr[4:3])
            jrr_pkg::REG_SOURCE_ADDRESS: prdata = {56'd0, sa_reg};
            jrr_pkg::REG_ECU_NAME:       prdata = name_reg;
            jrr_pkg::REG_DTC_COUNT:      prdata = {60'd0, count_reg};
            default:                     prdata = 64'd0;
        endcase
    end

    // Store write, out-of-range index dropped
    assign wr_idx   = IW'(in_ch.data.dtc_index);
    assign store_wr = in_fire && in_ch.data.func && (32'(in_ch.data.dtc_index) < DTC_DEPTH);

    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            store_reg[wr_idx] <= in_ch.data.dtc_code;
        end
    end

    // Frame fields of the captured item
    assign pf      = item_reg.can_id[23:16];
    assign ps      = item_reg.can_id[15:8];
    assign rsa     = item_reg.can_id[7:0];
    assign req_pgn = item_reg.payload[23:0];
    assign is_req  = (pf == jrr_pkg::PF_REQUEST) && (item_reg.byte_count >= 7'd3)
                     && (ps == jrr_pkg::ADDR_GLOBAL || ps == sa_reg);
    assign is_rts  = (pf == jrr_pkg::PF_TP_CM) && (ps == sa_reg)
                     && (item_reg.byte_count >= 7'd8)
                     && (item_reg.payload[7:0] == jrr_pkg::CTL_RTS);

    // Clamp the stored code count
    assign dtc_n = (32'(count_reg) > DTC_DEPTH) ? 5'(DTC_DEPTH) : {1'b0, count_reg};
    assign lamp_byte = {1'b0, item_reg.mil_lamp, 6'h3F};

    // BAM size: packets = ceil(total / 7) by reciprocal multiply
    assign bam_total = (req_pgn == jrr_pkg::PGN_DIAG1)
                       ? 7'(7'd2 + {dtc_n, 2'b00}) : 7'(ROM_LEN);
    assign pkts_arg  = bam_total + 7'd6;
    assign pkts_prod = 13'(pkts_arg) * 13'd37;
    assign pkts      = pkts_prod[12:8];
    assign sent_cnt  = (pkts > 5'(jrr_pkg::MAX_DATA_PKTS)) ? jrr_pkg::MAX_DATA_PKTS
                                                          : pkts[2:0];

    // Shared byte unit: one message byte per cycle
    assign dtc_off = ptr_reg - 7'd2;
    assign dtc_ent = dtc_off[5:2];
    always_comb
    begin
        if (32'(dtc_ent) < DTC_DEPTH)
        begin
            dtc_code_rd = store_reg[IW'(dtc_ent)];
        end
        else
        begin
            dtc_code_rd = 32'd0;
        end
        dtc_bytes = jrr_pkg::spn_bytes(dtc_code_rd);
        priority if (ptr_reg >= total_reg)
        begin
            fill_byte = 8'hFF;
        end
        else if (!dm1_reg)
        begin
            fill_byte = jrr_pkg::ident_byte(ptr_reg[5:0]);
        end
        else if (ptr_reg == 7'd0)
        begin
            fill_byte = lamp_byte;
        end
        else if (ptr_reg == 7'd1)
        begin
            fill_byte = 8'hFF;
        end
        else
        begin
            fill_byte = dtc_bytes[{dtc_off[1:0], 3'b000} +: 8];
        end
    end

    // Sequencer: next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        item_next      = item_reg;
        dm1_next       = dm1_reg;
        total_next     = total_reg;
        sent_next      = sent_reg;
        seq_next       = seq_reg;
        ptr_next       = ptr_reg;
        byte_cnt_next  = byte_cnt_reg;
        buf_next       = buf_reg;
        unique case (state_reg)
            jrr_pkg::ST_IDLE:
            begin
                // Capture a frame; store writes and standard frames end here
                if (in_fire && !in_ch.data.func && in_ch.data.is_extended)
                begin
                    item_next  = in_ch.data;
                    state_next = jrr_pkg::ST_DEC;
                end
            end
            jrr_pkg::ST_DEC:
            begin
                sent_next  = 3'd0;
                seq_next   = 3'd0;
                ptr_next   = 7'd0;
                byte_cnt_next = 3'd0;
                state_next = jrr_pkg::ST_SEND;
                out_valid_next = 1'b1;
                out_next.last  = 1'b1;
                if (is_req && req_pgn == jrr_pkg::PGN_ADDR_CLAIM)
                begin
                    out_next.tx_id = jrr_pkg::mk_id(3'd6, jrr_pkg::PF_ADDR_CLAIM,
                        (ps == jrr_pkg::ADDR_GLOBAL) ? jrr_pkg::ADDR_GLOBAL : rsa, sa_reg);
                    out_next.tx_payload = name_reg;
                end
                else if (is_req && req_pgn == jrr_pkg::PGN_DIAG1 && dtc_n <= 5'd1)
                begin
                    out_next.tx_id = jrr_pkg::mk_id(3'd6, jrr_pkg::PGN_DIAG1[15:8],
                                                    jrr_pkg::PGN_DIAG1[7:0], sa_reg);
                    out_next.tx_payload = {16'hFFFF,
                        (dtc_n == 5'd1) ? jrr_pkg::spn_bytes(store_reg[0]) : 32'd0,
                        8'hFF, lamp_byte};
                end
                else if (is_req && (req_pgn == jrr_pkg::PGN_DIAG1
                                    || req_pgn == jrr_pkg::PGN_ECU_IDENT))
                begin
                    // BAM announcement
                    dm1_next   = (req_pgn == jrr_pkg::PGN_DIAG1);
                    total_next = bam_total;
                    sent_next  = sent_cnt;
                    out_next.tx_id = jrr_pkg::mk_id(3'd7, jrr_pkg::PF_TP_CM,
                                                    jrr_pkg::ADDR_GLOBAL, sa_reg);
                    out_next.tx_payload = {req_pgn, 8'hFF, 3'b000, pkts, 8'h00,
                                           1'b0, bam_total, jrr_pkg::CTL_BAM};
                    out_next.last = (sent_cnt == 3'd0);
                end
                else if (is_req && ps == sa_reg)
                begin
                    out_next.tx_id = jrr_pkg::mk_id(3'd6, jrr_pkg::PF_ACK, rsa, sa_reg);
                    out_next.tx_payload = jrr_pkg::ctl_frame(jrr_pkg::CTL_NACK, req_pgn);
                end
                else if (!is_req && is_rts)
                begin
                    out_next.tx_id = jrr_pkg::mk_id(3'd7, jrr_pkg::PF_TP_CM, rsa, sa_reg);
                    out_next.tx_payload = jrr_pkg::ctl_frame(jrr_pkg::CTL_ABORT,
                                                             item_reg.payload[63:40]);
                end
                else
                begin
                    // Nothing to answer
                    out_valid_next = 1'b0;
                    state_next     = jrr_pkg::ST_IDLE;
                end
            end
            jrr_pkg::ST_FILL:
            begin
                // Shift one byte in; load the frame after the seventh
                buf_next      = {fill_byte, buf_reg[55:8]};
                ptr_next      = ptr_reg + 7'd1;
                byte_cnt_next = byte_cnt_reg + 3'd1;
                if (byte_cnt_reg == 3'd6)
                begin
                    out_next.tx_id = jrr_pkg::mk_id(3'd7, jrr_pkg::PF_TP_DT,
                                                    jrr_pkg::ADDR_GLOBAL, sa_reg);
                    out_next.tx_payload = {fill_byte, buf_reg[55:8], 5'd0, seq_reg};
                    out_next.last  = (seq_reg == sent_reg);
                    out_valid_next = 1'b1;
                    byte_cnt_next  = 3'd0;
                    state_next     = jrr_pkg::ST_SEND;
                end
            end
            jrr_pkg::ST_SEND:
            begin
                // Hold until taken, then advance to the next packet or return to idle
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    if (seq_reg < sent_reg)
                    begin
                        seq_next   = seq_reg + 3'd1;
                        state_next = jrr_pkg::ST_FILL;
                    end
                    else
                    begin
                        state_next = jrr_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = jrr_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jrr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and sequencing registers
    always_ff @(posedge clk)
    begin
        out_reg      <= out_next;
        item_reg     <= item_next;
        dm1_reg      <= dm1_next;
        total_reg    <= total_next;
        sent_reg     <= sent_next;
        seq_reg      <= seq_next;
        ptr_reg      <= ptr_next;
        byte_cnt_reg <= byte_cnt_next;
        buf_reg      <= buf_next;
    end

endmodule

[bench/j1939_request_responder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// j1939_request_responder_tb
// Self-checking bench for the J1939 responder: directed requests, then random
// frames and store writes, with an in-bench model of the expected frames and
// random stalls on both channels.
// ----------------------------------------------------------------------------
module j1939_request_responder_tb;

    localparam int DEPTH = 8;
    localparam int IDENT_LEN = 22;
    localparam int STALL_LIMIT = 20000;
    // Identification string, byte 0 in the low bits
    localparam logic [175:0] IDENT_STR =
        176'h2A31_5449_4E55_2A31_3030_302A_415F_5543_452A_4E4D_4152;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;

    jrr_in_if in_ch ();
    jrr_out_if out_ch ();

    j1939_request_responder dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Model state
    logic [7:0] my_addr;
    logic [63:0] my_name;
    logic [3:0] code_count;
    logic [31:0] code_store [DEPTH];
    jrr_pkg::out_item_t frames_due [$];
    int errors = 0;
    int idle_cycles = 0;
    bit sink_busy = 1'b0;
    logic [3:0] code_count_set [6] = '{4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd15};

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog on accepted traffic
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("j1939_request_responder_tb NOT OK");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // Check each sent frame against the oldest expected one
    always @(posedge clk)
    begin
        jrr_pkg::out_item_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            if (frames_due.size() == 0)
                report("unexpected frame", 64'(out_ch.data.tx_id), 64'd0);
            else
            begin
                want = frames_due.pop_front();
                if (out_ch.data.tx_id !== want.tx_id)
                    report("tx_id", 64'(out_ch.data.tx_id), 64'(want.tx_id));
                if (out_ch.data.tx_payload !== want.tx_payload)
                    report("tx_payload", out_ch.data.tx_payload, want.tx_payload);
                if (out_ch.data.last !== want.last)
                    report("last", 64'(out_ch.data.last), 64'(want.last));
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Random back-pressure on the output side, with quiet stretches
    initial
    begin
        int n;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!sink_busy && $urandom_range(0, 3) == 0)
            begin
                n = gap_len();
                if (n > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (n) @(negedge clk);
                end
            end
            out_ch.ready <= 1'b1;
        end
    end

    function automatic jrr_pkg::out_item_t frame(logic [28:0] id, logic [63:0] pl, logic lst);
        jrr_pkg::out_item_t f;
        f.tx_id = id;
        f.tx_payload = pl;
        f.last = lst;
        return f;
    endfunction

    function automatic void queue_bam(logic [23:0] pgn, logic [7:0] msg [], int total);
        int pkts;
        int sent;
        logic [63:0] w;
        pkts = (total + 6) / 7;
        sent = pkts > int'(jrr_pkg::MAX_DATA_PKTS) ? int'(jrr_pkg::MAX_DATA_PKTS) : pkts;
        w = {pgn, 8'hFF, pkts[7:0], total[15:0], jrr_pkg::CTL_BAM};
        frames_due.push_back(frame(jrr_pkg::mk_id(3'd7, jrr_pkg::PF_TP_CM,
                                   jrr_pkg::ADDR_GLOBAL, my_addr), w, sent == 0));
        for (int s = 1; s <= sent; s++)
        begin
            w = '1;
            w[7:0] = s[7:0];
            for (int j = 0; j < 7 && (s - 1) * 7 + j < total; j++)
                w[8 * (j + 1) +: 8] = msg[(s - 1) * 7 + j];
            frames_due.push_back(frame(jrr_pkg::mk_id(3'd7, jrr_pkg::PF_TP_DT,
                                       jrr_pkg::ADDR_GLOBAL, my_addr), w, s == sent));
        end
    endfunction

    function automatic logic [31:0] dm1_code_bytes(logic [31:0] code);
        logic [13:0] fault;
        logic [15:0] spn;
        logic [4:0] fmi;
        fault = code[29:16];
        spn = {2'b00, fault};
        fmi = 5'd31;
        if (code[31:30] == 2'd3 && fault == 14'h0029)
        begin
            spn = 16'd639;
            fmi = 5'd9;
        end
        else if (code[31:30] == 2'd1 && fault == 14'h0563)
        begin
            spn = 16'd628;
            fmi = 5'd13;
        end
        else if (code[31:30] == 2'd0 && fault == 14'h0172)
        begin
            spn = 16'd3055;
            fmi = 5'd0;
        end
        else if (code[31:30] == 2'd2 && fault == 14'h0091)
        begin
            spn = 16'd2872;
            fmi = 5'd2;
        end
        return {8'h01, 3'b000, fmi, spn};
    endfunction

    // Work out the frames one accepted item causes
    function automatic void predict_response(jrr_pkg::in_item_t it);
        logic [7:0] pf, ps, rsa;
        logic [23:0] pgn;
        logic [7:0] msg [];
        logic [31:0] cb;
        int n;
        if (it.func)
        begin
            code_store[it.dtc_index] = it.dtc_code;
            return;
        end
        if (!it.is_extended) return;
        pf = it.can_id[23:16];
        ps = it.can_id[15:8];
        rsa = it.can_id[7:0];
        if (pf == jrr_pkg::PF_REQUEST && it.byte_count >= 7'd3
            && (ps == jrr_pkg::ADDR_GLOBAL || ps == my_addr))
        begin
            pgn = it.payload[23:0];
            if (pgn == jrr_pkg::PGN_ADDR_CLAIM)
                frames_due.push_back(frame(jrr_pkg::mk_id(3'd6, jrr_pkg::PF_ADDR_CLAIM,
                    ps == jrr_pkg::ADDR_GLOBAL ? jrr_pkg::ADDR_GLOBAL : rsa, my_addr),
                    my_name, 1'b1));
            else if (pgn == jrr_pkg::PGN_ECU_IDENT)
            begin
                msg = new[IDENT_LEN];
                for (int k = 0; k < IDENT_LEN; k++)
                begin
                    if (k < 22)
                        msg[k] = IDENT_STR[8 * k +: 8];
                    else
                        msg[k] = 8'h20;
                end
                queue_bam(jrr_pkg::PGN_ECU_IDENT, msg, IDENT_LEN);
            end
            else if (pgn == jrr_pkg::PGN_DIAG1)
            begin
                n = int'(code_count) > DEPTH ? DEPTH : int'(code_count);
                if (n <= 1)
                begin
                    cb = n == 1 ? dm1_code_bytes(code_store[0]) : 32'h0;
                    frames_due.push_back(frame(jrr_pkg::mk_id(3'd6,
                        jrr_pkg::PGN_DIAG1[15:8], jrr_pkg::PGN_DIAG1[7:0], my_addr),
                        {16'hFFFF, cb, 8'hFF, 1'b0, it.mil_lamp, 6'h3F}, 1'b1));
                end
                else
                begin
                    msg = new[2 + 4 * n];
                    msg[0] = {1'b0, it.mil_lamp, 6'h3F};
                    msg[1] = 8'hFF;
                    for (int i = 0; i < n; i++)
                    begin
                        cb = dm1_code_bytes(code_store[i]);
                        for (int b = 0; b < 4; b++) msg[2 + 4 * i + b] = cb[8 * b +: 8];
                    end
                    queue_bam(jrr_pkg::PGN_DIAG1, msg, 2 + 4 * n);
                end
            end
            else if (ps == my_addr)
                frames_due.push_back(frame(jrr_pkg::mk_id(3'd6, jrr_pkg::PF_ACK, rsa, my_addr),
                                           {pgn, 32'hFFFF_FFFF, jrr_pkg::CTL_NACK}, 1'b1));
        end
        else if (pf == jrr_pkg::PF_TP_CM && ps == my_addr && it.byte_count >= 7'd8 &&
                 it.payload[7:0] == jrr_pkg::CTL_RTS)
            frames_due.push_back(frame(jrr_pkg::mk_id(3'd7, jrr_pkg::PF_TP_CM, rsa, my_addr),
                {it.payload[63:40], 32'hFFFF_FFFF, jrr_pkg::CTL_ABORT}, 1'b1));
    endfunction

    function automatic jrr_pkg::in_item_t rand_item();
        jrr_pkg::in_item_t it;
        it.func = 1'($urandom);
        it.is_extended = 1'($urandom);
        it.can_id = 29'($urandom);
        it.byte_count = 7'($urandom);
        it.payload = {$urandom, $urandom};
        it.mil_lamp = 1'($urandom);
        it.dtc_index = 3'($urandom);
        it.dtc_code = $urandom;
        return it;
    endfunction

    // Drop the input valid and scramble the payload
    task automatic in_idle();
        in_ch.valid <= 1'b0;
        in_ch.data <= rand_item();
    endtask

    // Send one item, with a random gap first
    task automatic send_item(jrr_pkg::in_item_t it);
        int n;
        n = gap_len();
        if ($urandom_range(0, 9) < 3) n = 0;
        if (n > 0)
        begin
            in_idle();
            repeat (n) @(negedge clk);
        end
        in_ch.data <= it;
        in_ch.valid <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        predict_response(it);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_idle();
        while (frames_due.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        in_idle();
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            jrr_pkg::REG_SOURCE_ADDRESS: my_addr = value[7:0];
            jrr_pkg::REG_ECU_NAME: my_name = value;
            default: code_count = value[3:0];
        endcase
    endtask

    function automatic jrr_pkg::in_item_t frame_item(logic [7:0] pf, logic [7:0] ps,
                                                     logic [63:0] pl);
        jrr_pkg::in_item_t it;
        it = rand_item();
        it.func = 1'b0;
        it.is_extended = 1'b1;
        it.can_id = {5'($urandom_range(0, 31)), pf, ps, 8'($urandom)};
        it.byte_count = 7'($urandom_range(8, 64));
        it.payload = pl;
        return it;
    endfunction

    function automatic jrr_pkg::in_item_t code_write(logic [2:0] idx, logic [31:0] code);
        jrr_pkg::in_item_t it;
        it = rand_item();
        it.func = 1'b1;
        it.dtc_index = idx;
        it.dtc_code = code;
        return it;
    endfunction

    function automatic logic [31:0] rand_code();
        case ($urandom_range(0, 4))
            0: return {2'd3, 14'h0029, 16'($urandom)};
            1: return {2'd1, 14'h0563, 16'($urandom)};
            2: return {2'd0, 14'h0172, 16'($urandom)};
            3: return {2'd2, 14'h0091, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] req_pl(logic [23:0] pgn);
        return {$urandom, 8'($urandom), pgn};
    endfunction

    // Fill the whole store so later DM1 reads are defined
    task automatic test_store_fill();
        for (int i = 0; i < DEPTH; i++) send_item(code_write(i[2:0], rand_code()));
    endtask

    // Requests of every kind, extremes of address and count
    task automatic test_directed();
        jrr_pkg::in_item_t it;
        write_reg(jrr_pkg::REG_ECU_NAME, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(frame_item(jrr_pkg::PF_REQUEST, 8'h80, req_pl(jrr_pkg::PGN_ADDR_CLAIM)));
        send_item(frame_item(jrr_pkg::PF_REQUEST, jrr_pkg::ADDR_GLOBAL,
                             req_pl(jrr_pkg::PGN_ADDR_CLAIM)));
        send_item(frame_item(jrr_pkg::PF_REQUEST, jrr_pkg::ADDR_GLOBAL,
                             req_pl(jrr_pkg::PGN_ECU_IDENT)));
        send_item(frame_item(jrr_pkg::PF_REQUEST, 8'h80, req_pl(jrr_pkg::PGN_DIAG1)));
        send_item(frame_item(jrr_pkg::PF_REQUEST, 8'h80, req_pl(24'h123456)));
        send_item(frame_item(jrr_pkg::PF_REQUEST, jrr_pkg::ADDR_GLOBAL, req_pl(24'h123456)));
        send_item(frame_item(jrr_pkg::PF_TP_CM, 8'h80,
                             {$urandom, 24'($urandom), jrr_pkg::CTL_RTS}));
        it = frame_item(jrr_pkg::PF_TP_CM, 8'h80, {$urandom, 24'($urandom), jrr_pkg::CTL_RTS});
        it.byte_count = 7'd7;
        send_item(it);
        it = frame_item(jrr_pkg::PF_REQUEST, 8'h80, req_pl(jrr_pkg::PGN_ADDR_CLAIM));
        it.byte_count = 7'd2;
        send_item(it);
        it.byte_count = 7'd3;
        send_item(it);
        it.is_extended = 1'b0;
        send_item(it);
        send_item(frame_item(jrr_pkg::PF_REQUEST, 8'h55, req_pl(jrr_pkg::PGN_ADDR_CLAIM)));
        wait_drained();
        foreach (code_count_set[k])
        begin
            write_reg(jrr_pkg::REG_DTC_COUNT, 64'(code_count_set[k]));
            send_item(frame_item(jrr_pkg::PF_REQUEST, jrr_pkg::ADDR_GLOBAL,
                                 req_pl(jrr_pkg::PGN_DIAG1)));
            wait_drained();
        end
        write_reg(jrr_pkg::REG_SOURCE_ADDRESS, 64'hFF);
        write_reg(jrr_pkg::REG_ECU_NAME, 64'h0);
        send_item(frame_item(jrr_pkg::PF_REQUEST, 8'hFF, req_pl(jrr_pkg::PGN_ADDR_CLAIM)));
        send_item(frame_item(jrr_pkg::PF_REQUEST, 8'hFF, req_pl(24'hFFFFFF)));
        send_item(frame_item(jrr_pkg::PF_TP_CM, 8'hFF,
                             {$urandom, 24'($urandom), jrr_pkg::CTL_RTS}));
        wait_drained();
        write_reg(jrr_pkg::REG_SOURCE_ADDRESS, 64'h00);
        send_item(frame_item(jrr_pkg::PF_REQUEST, 8'h00, req_pl(jrr_pkg::PGN_ADDR_CLAIM)));
        wait_drained();
    endtask

    // Random phases over several register settings
    task automatic test_random();
        jrr_pkg::in_item_t it;
        logic [7:0] pf, ps;
        logic [23:0] pgn;
        int r;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(jrr_pkg::REG_SOURCE_ADDRESS,
                      64'(phase == 4 ? 8'd253 : 8'($urandom_range(0, 255))));
            write_reg(jrr_pkg::REG_ECU_NAME, {$urandom, $urandom});
            write_reg(jrr_pkg::REG_DTC_COUNT, 64'($urandom_range(0, 15)));
            sink_busy = (phase == 2);
            for (int k = 0; k < 100; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    it = code_write(3'($urandom), rand_code());
                else if (r < 85)
                begin
                    case ($urandom_range(0, 4))
                        0: pgn = jrr_pkg::PGN_ADDR_CLAIM;
                        1: pgn = jrr_pkg::PGN_ECU_IDENT;
                        2: pgn = jrr_pkg::PGN_DIAG1;
                        default: pgn = 24'($urandom);
                    endcase
                    ps = $urandom_range(0, 1) ? my_addr : jrr_pkg::ADDR_GLOBAL;
                    if ($urandom_range(0, 7) == 0) ps = 8'($urandom);
                    it = frame_item(jrr_pkg::PF_REQUEST, ps, req_pl(pgn));
                    it.byte_count = $urandom_range(0, 9) == 0 ? 7'($urandom_range(0, 127))
                                                              : 7'($urandom_range(3, 8));
                end
                else if (r < 95)
                begin
                    pf = jrr_pkg::PF_TP_CM;
                    it = frame_item(pf, $urandom_range(0, 3) ? my_addr : 8'($urandom),
                                    {$urandom, 24'($urandom),
                                     $urandom_range(0, 3) ? jrr_pkg::CTL_RTS : 8'($urandom)});
                    if ($urandom_range(0, 5) == 0) it.byte_count = 7'($urandom_range(0, 127));
                end
                else
                begin
                    it = rand_item();
                    it.func = 1'b0;
                end
                send_item(it);
            end
            wait_drained();
        end
        sink_busy = 1'b0;
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        my_addr = 8'd128;
        my_name = '0;
        code_count = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_store_fill();
        test_directed();
        test_random();
        wait_drained();
        if (errors == 0)
            $display("j1939_request_responder_tb OK");
        else
            $display("j1939_request_responder_tb NOT OK");
        $finish;
    end
endmodule

[files.f]
design/jrr_pkg.sv
design/jrr_in_if.sv
design/jrr_out_if.sv
design/j1939_request_responder.sv
bench/j1939_request_responder_tb.sv
